// File: hdl/brace_group_command_tokenizer_macros.svh
// Assertion macros for the brace group command tokenizer.
// Used by the RTL modules under hdl; no other dependency.
`ifndef BRACE_GROUP_COMMAND_TOKENIZER_MACROS_SVH
`define BRACE_GROUP_COMMAND_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BGCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgct: implication check failed");
// Next-cycle implication.
`define BGCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgct: next-cycle check failed");
`else
`define BGCT_ASSERT_IMP(lbl, ante, cons)
`define BGCT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/bgct_pkg.sv
// Package for the brace group command tokenizer: types, codes, constants.
// No dependencies; imported by bgct_front, bgct_queue, bgct_back and the top.
package bgct_pkg;

  localparam int MAX_TOKENS_DEF = 16;
  localparam int LINE_BYTES_DEF = 256;

  // Command queue between parser and emitter (depth must be a power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_TOKEN   = 2'd1,
    MODE_GROUP   = 2'd2,
    MODE_SKIP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_UNCLOSED = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_LONG     = 2'd3
  } status_t;

  // One parser command: an optional token and an optional end item
  typedef struct packed {
    logic       has_tok;
    logic       has_end;
    logic [7:0] tok_start;
    logic [7:0] tok_len;
    logic [3:0] tok_num;
    logic       tok_grp;
    logic [4:0] total;
    status_t    status;
  } cmd_t;

  // One result item as presented on the output channel
  typedef struct packed {
    logic [7:0] token_start;
    logic [7:0] token_length;
    logic [3:0] token_number;
    logic       from_group;
    logic       end_of_line;
    logic [4:0] token_total;
    logic [1:0] line_status;
  } res_t;

endpackage

// File: hdl/bgct_ifs.sv
// Valid/ready channel interfaces for the tokenizer's byte input and result output.
// Depends on nothing.
interface bgct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

interface bgct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_start;
  logic [7:0] token_length;
  logic [3:0] token_number;
  logic       from_group;
  logic       end_of_line;
  logic [4:0] token_total;
  logic [1:0] line_status;

  modport source (output valid, output token_start, output token_length,
                  output token_number, output from_group, output end_of_line,
                  output token_total, output line_status, input ready);
  modport sink   (input valid, input token_start, input token_length,
                  input token_number, input from_group, input end_of_line,
                  input token_total, input line_status, output ready);
endinterface

// File: hdl/bgct_front.sv
// Parser front end: takes one byte per cycle while the queue has room, tracks
// token state, pushes token/end commands. Uses bgct_pkg, bgct_in_if, macros.
`include "brace_group_command_tokenizer_macros.svh"
module bgct_front #(
  parameter int MAX_TOKENS = bgct_pkg::MAX_TOKENS_DEF,
  parameter int LINE_BYTES = bgct_pkg::LINE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  bgct_in_if.sink         in_if,
  input  logic            q_full,
  output logic            q_push,
  output bgct_pkg::cmd_t  q_cmd
);
  import bgct_pkg::*;

  localparam int POS_W = $clog2(LINE_BYTES);
  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TOKENS);

  mode_t            mode_r, mode_nxt;
  status_t          stop_r, stop_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] open_r, open_nxt;
  logic [POS_W-1:0] gfirst_r, gfirst_nxt;
  logic [POS_W-1:0] glast_r, glast_nxt;
  logic             gseen_r, gseen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept;
  logic [7:0]       b;
  logic             tok_v;
  logic             eol;
  logic [POS_W-1:0] tok_start;
  logic [POS_W-1:0] tok_len;
  logic             tok_grp;
  logic [CNT_W-1:0] cnt_inc;
  status_t          status_e;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign b           = in_if.line_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BETWEEN;
      stop_r   <= ST_NORMAL;
      pos_r    <= '0;
      open_r   <= '0;
      gfirst_r <= '0;
      glast_r  <= '0;
      gseen_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      stop_r   <= stop_nxt;
      pos_r    <= pos_nxt;
      open_r   <= open_nxt;
      gfirst_r <= gfirst_nxt;
      glast_r  <= glast_nxt;
      gseen_r  <= gseen_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    stop_nxt   = stop_r;
    pos_nxt    = pos_r;
    open_nxt   = open_r;
    gfirst_nxt = gfirst_r;
    glast_nxt  = glast_r;
    gseen_nxt  = gseen_r;
    cnt_nxt    = cnt_r;
    tok_v      = 1'b0;
    eol        = 1'b0;
    tok_start  = '0;
    tok_len    = '0;
    tok_grp    = 1'b0;
    status_e   = stop_r;
    cnt_inc    = cnt_r;

    if (accept) begin
      priority if (b == CH_NUL) begin
        // end of line: flush an open token, close out, clear for next line
        eol = 1'b1;
        if (mode_r == MODE_TOKEN) begin
          tok_v     = 1'b1;
          tok_start = open_r;
          tok_len   = pos_r - open_r;
        end else if (mode_r == MODE_GROUP && stop_r == ST_NORMAL) begin
          status_e  = ST_UNCLOSED;
        end
        cnt_inc    = cnt_r + CNT_W'(tok_v);
        mode_nxt   = MODE_BETWEEN;
        stop_nxt   = ST_NORMAL;
        pos_nxt    = '0;
        open_nxt   = '0;
        gfirst_nxt = '0;
        glast_nxt  = '0;
        gseen_nxt  = 1'b0;
        cnt_nxt    = '0;
      end else if (mode_r == MODE_SKIP) begin
        // ignoring bytes until the zero byte
      end else if (pos_r >= LAST_POS) begin
        mode_nxt = MODE_SKIP;
        stop_nxt = ST_LONG;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (mode_r == MODE_GROUP) begin
          if (b == CH_RBRACE) begin
            if (gseen_r) begin
              tok_v     = 1'b1;
              tok_grp   = 1'b1;
              tok_start = gfirst_r;
              tok_len   = glast_r - gfirst_r + 1'b1;
            end
            mode_nxt = MODE_BETWEEN;
          end else if (b != CH_SPACE) begin
            if (!gseen_r) gfirst_nxt = pos_r;
            gseen_nxt = 1'b1;
            glast_nxt = pos_r;
          end
        end else if (b == CH_SPACE || b == CH_NL || b == CH_RBRACE) begin
          if (mode_r == MODE_TOKEN) begin
            tok_v     = 1'b1;
            tok_start = open_r;
            tok_len   = pos_r - open_r;
          end
          mode_nxt = MODE_BETWEEN;
        end else if (b == CH_LBRACE) begin
          if (mode_r == MODE_TOKEN) begin
            tok_v     = 1'b1;
            tok_start = open_r;
            tok_len   = pos_r - open_r;
          end
          mode_nxt   = MODE_GROUP;
          gseen_nxt  = 1'b0;
          gfirst_nxt = '0;
          glast_nxt  = '0;
        end else if (mode_r == MODE_BETWEEN) begin
          open_nxt = pos_r;
          mode_nxt = MODE_TOKEN;
        end
        cnt_inc = cnt_r + CNT_W'(tok_v);
        cnt_nxt = cnt_inc;
        // limit reached on a non-zero byte: drop the rest of the line
        if (cnt_inc >= CNT_MAX) begin
          mode_nxt = MODE_SKIP;
          stop_nxt = ST_LIMIT;
        end
      end
    end
  end

  assign q_push          = accept && (tok_v || eol);
  assign q_cmd.has_tok   = tok_v;
  assign q_cmd.has_end   = eol;
  assign q_cmd.tok_start = 8'(tok_start);
  assign q_cmd.tok_len   = 8'(tok_len);
  assign q_cmd.tok_num   = 4'(cnt_r);
  assign q_cmd.tok_grp   = tok_grp;
  assign q_cmd.total     = 5'(cnt_inc);
  assign q_cmd.status    = status_e;

  `BGCT_ASSERT_IMP(a_skip_has_reason, mode_r == MODE_SKIP, stop_r != ST_NORMAL)
  `BGCT_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= CNT_MAX)
  `BGCT_ASSERT_IMP(a_group_order, mode_r == MODE_GROUP && gseen_r, gfirst_r <= glast_r)
endmodule

// File: hdl/bgct_queue.sv
// Short command queue between parser and emitter, register storage.
// Uses bgct_pkg and the assertion macros.
`include "brace_group_command_tokenizer_macros.svh"
module bgct_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bgct_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output bgct_pkg::cmd_t head,
  output logic           empty
);
  import bgct_pkg::*;

  localparam logic [QPTR_W:0] DEPTH = (QPTR_W + 1)'(QUEUE_DEPTH);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == DEPTH);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

  `BGCT_ASSERT_IMP(a_no_overflow, push, !full)
  `BGCT_ASSERT_IMP(a_no_underflow, pop, !empty)
  `BGCT_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= DEPTH)
endmodule

// File: hdl/bgct_back.sv
// Result emitter: pops commands and drives the output register, splitting a
// command that holds a token and an end item into two items. Uses bgct_pkg.
`include "brace_group_command_tokenizer_macros.svh"
module bgct_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  bgct_pkg::cmd_t q_head,
  output logic           q_pop,
  bgct_out_if.source     out_if
);
  import bgct_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  res_t       res_r, res_nxt;
  logic       pend_r, pend_nxt;
  logic [4:0] pend_total_r, pend_total_nxt;
  status_t    pend_status_r, pend_status_nxt;
  logic       load;

  function automatic res_t end_item(input logic [4:0] total, input status_t st);
    res_t r;
    r              = '0;
    r.end_of_line  = 1'b1;
    r.token_total  = total;
    r.line_status  = st;
    return r;
  endfunction

  assign load = !out_valid_r || out_if.ready;

  always_comb begin
    q_pop           = 1'b0;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    res_nxt         = res_r;
    pend_nxt        = pend_r;
    pend_total_nxt  = pend_total_r;
    pend_status_nxt = pend_status_r;
    if (load) begin
      priority if (pend_r) begin
        out_valid_nxt = 1'b1;
        res_nxt       = end_item(pend_total_r, pend_status_r);
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        q_pop           = 1'b1;
        out_valid_nxt   = 1'b1;
        pend_total_nxt  = q_head.total;
        pend_status_nxt = q_head.status;
        if (q_head.has_tok) begin
          res_nxt              = '0;
          res_nxt.token_start  = q_head.tok_start;
          res_nxt.token_length = q_head.tok_len;
          res_nxt.token_number = q_head.tok_num;
          res_nxt.from_group   = q_head.tok_grp;
          pend_nxt             = q_head.has_end;
        end else begin
          res_nxt = end_item(q_head.total, q_head.status);
        end
      end else begin
        // nothing owed and nothing queued: output register drains
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r         <= res_nxt;
    pend_total_r  <= pend_total_nxt;
    pend_status_r <= pend_status_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.token_start  = res_r.token_start;
  assign out_if.token_length = res_r.token_length;
  assign out_if.token_number = res_r.token_number;
  assign out_if.from_group   = res_r.from_group;
  assign out_if.end_of_line  = res_r.end_of_line;
  assign out_if.token_total  = res_r.token_total;
  assign out_if.line_status  = res_r.line_status;

  `BGCT_ASSERT_IMP(a_pend_needs_out, pend_r, out_valid_r)
  `BGCT_ASSERT_IMP(a_pend_blocks_pop, pend_r, !q_pop)
  `BGCT_ASSERT_NXT(a_split_sets_pend, q_pop && q_head.has_tok && q_head.has_end, pend_r)
endmodule

// File: hdl/brace_group_command_tokenizer.sv
// Top level of the brace group command tokenizer.
// Depends on bgct_pkg, bgct_ifs, bgct_front, bgct_queue and bgct_back.
//
// Use: bytes of a line arrive on in_if (valid/ready, field line_byte), one
// item per byte; a zero byte ends the line. Results leave on out_if: one item
// per token (start offset, length, index, group flag) as its end is seen,
// then one end item per line carrying the token count and the line status.
// A result is registered first in a queue entry, then in the output register,
// before it is presented on out_if.
// Throughput: one byte per cycle while in_if.ready is high. A zero byte that
// closes a plain token yields two output items; the four-entry command queue
// absorbs this, and in_if.ready drops only when that queue is full.
// Reset (rst_n low, synchronous): the parser returns to the start of a line
// with no open token, and the queue and output register are emptied.
// Receiver stall: out_if holds its item while ready is low; the parser keeps
// accepting bytes until the queue fills, then back-pressures in_if.
module brace_group_command_tokenizer #(
  parameter int MAX_TOKENS = bgct_pkg::MAX_TOKENS_DEF,
  parameter int LINE_BYTES = bgct_pkg::LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bgct_in_if.sink    in_if,
  bgct_out_if.source out_if
);
  import bgct_pkg::*;

  // Parser to queue
  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  // Queue to emitter
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  // Front: classify each byte, keep offsets and counts, emit commands
  bgct_front #(
    .MAX_TOKENS (MAX_TOKENS),
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  // Decoupling queue so a stalled receiver does not stop the parser at once
  bgct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back: serialise commands onto the output channel
  bgct_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );
endmodule
